### sv/tct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tct_pkg
// Shared constants, command and status codes, and the structs that pass
// between the tracker sequencer and the top level.
// ----------------------------------------------------------------------------
package tct_pkg;

    // Store geometry and field widths
    localparam int TEXT_DEPTH = 1024;
    localparam int CHAR_W     = 16;
    localparam int ADDR_W     = $clog2(TEXT_DEPTH);
    localparam int LEN_W      = 10;
    localparam int POS_W      = ADDR_W + 1;
    localparam int CNT_W      = 16;
    localparam int CMD_W      = 2;
    localparam int CFG_ADDR_W = 1;

    // Stream packing
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 8;
    localparam int OUT_DATA_W = 48;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SRC_LEN = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TRN_LEN = 1'b1;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TEST    = 2'd0,
        CMD_WR_SRC  = 2'd1,
        CMD_WR_TRN  = 2'd2,
        CMD_RESTART = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_MISS    = 2'd0,
        ST_ADVANCE = 2'd1,
        ST_REPEAT  = 2'd2,
        ST_ACK     = 2'd3
    } t_status;

    // Write and read requests toward both text RAMs
    typedef struct packed {
        logic              src_we;
        logic              trn_we;
        logic [ADDR_W-1:0] waddr;
        logic [CHAR_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    // One finished result
    typedef struct packed {
        logic             mode;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] faults;
        logic [CNT_W-1:0] hits;
        t_status          status;
    } t_result;

endpackage
`default_nettype wire

### sv/tct_text_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tct_text_ram
// Simple dual-port text store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tct_text_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### sv/tct_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tct_seq
// Tracking sequencer: holds lengths, position, counts and mode, drives the
// text RAM ports and steps one shared character compare over the texts.
// ----------------------------------------------------------------------------
module tct_seq
    import tct_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request side
    input  wire logic                  i_req_valid,
    input  wire t_cmd                  i_req_cmd,
    input  wire logic [ADDR_W-1:0]     i_req_index,
    input  wire logic [CHAR_W-1:0]     i_req_char,
    output logic                       o_req_ready,
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [LEN_W-1:0]      i_cfg_wdata,
    // text RAMs
    output t_ram_req                   o_ram,
    input  wire logic [CHAR_W-1:0]     i_src_rdata,
    input  wire logic [CHAR_W-1:0]     i_trn_rdata,
    // result side
    input  wire logic                  i_out_free,
    output logic                       o_done,
    output t_result                    o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REP,
        S_REP_CMP,
        S_SCAN,
        S_SCAN_CMP,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [LEN_W-1:0]  r_src_len;
    logic [LEN_W-1:0]  r_trn_len;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  r_p;
    logic [CNT_W-1:0]  r_hits;
    logic [CNT_W-1:0]  r_faults;
    logic              r_mode;
    logic              r_sel_trn;
    logic [CHAR_W-1:0] r_ch;
    t_status           r_status;

    logic [POS_W-1:0]  w_len;
    logic [POS_W-1:0]  w_pos_m1;
    logic [CHAR_W-1:0] w_rdata;
    logic              w_eq;
    logic              w_text_end;

    // Select the text under test; the length bounds every read
    assign w_len    = r_sel_trn ? POS_W'(r_trn_len) : POS_W'(r_src_len);
    assign w_rdata  = r_sel_trn ? i_trn_rdata : i_src_rdata;
    assign w_pos_m1 = r_pos - 1'b1;

    // Shared compare against the character under test
    assign w_eq = (w_rdata == r_ch);

    // Scan stops past the length or on a stored null
    assign w_text_end = ((r_state == S_SCAN) && !(r_p < w_len)) ||
                        ((r_state == S_SCAN_CMP) && (w_rdata == '0));

    // RAM requests: writes at accept, reads from the sequencer address
    always_comb begin
        o_ram.src_we = (r_state == S_IDLE) && i_req_valid && (i_req_cmd == CMD_WR_SRC);
        o_ram.trn_we = (r_state == S_IDLE) && i_req_valid && (i_req_cmd == CMD_WR_TRN);
        o_ram.waddr  = i_req_index;
        o_ram.wdata  = i_req_char;
        o_ram.raddr  = (r_state == S_REP) ? w_pos_m1[ADDR_W-1:0] : r_p[ADDR_W-1:0];
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_done      = (r_state == S_DONE) && i_out_free;

    always_comb begin
        o_result.mode   = r_mode;
        o_result.pos    = r_pos;
        o_result.faults = r_faults;
        o_result.hits   = r_hits;
        o_result.status = r_status;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_len <= '0;
            r_trn_len <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_SRC_LEN) begin
                r_src_len <= i_cfg_wdata;
            end
            if (i_cfg_addr == CFG_TRN_LEN) begin
                r_trn_len <= i_cfg_wdata;
            end
        end
    end

    // Sequencer and tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_hits    <= '0;
            r_faults  <= '0;
            r_mode    <= 1'b0;
            r_sel_trn <= 1'b0;
            r_status  <= ST_ACK;
        end else if (w_text_end) begin
            // Nothing in this text: fall back to translated, or record a miss
            if (!r_sel_trn) begin
                r_sel_trn <= 1'b1;
                r_state   <= S_REP;
            end else begin
                r_hits   <= '0;
                if (r_faults != COUNT_MAX) begin
                    r_faults <= r_faults + 1'b1;
                end
                r_status <= ST_MISS;
                r_state  <= S_DONE;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_ch      <= i_req_char;
                        r_sel_trn <= r_mode;
                        r_status  <= ST_ACK;
                        r_state   <= S_DONE;
                        case (i_req_cmd)
                            CMD_TEST: begin
                                if (i_req_char != '0) begin
                                    r_state <= S_REP;
                                end
                            end
                            CMD_RESTART: begin
                                r_pos    <= '0;
                                r_hits   <= '0;
                                r_faults <= '0;
                                r_mode   <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_REP: begin
                    // Check the character just before the position
                    r_p <= r_pos;
                    if ((r_pos != '0) && (w_pos_m1 < w_len)) begin
                        r_state <= S_REP_CMP;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_REP_CMP: begin
                    if (w_eq) begin
                        r_status <= ST_REPEAT;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_state <= S_SCAN_CMP;
                end
                S_SCAN_CMP: begin
                    if (w_eq) begin
                        r_pos    <= r_p + 1'b1;
                        if (r_hits != COUNT_MAX) begin
                            r_hits <= r_hits + 1'b1;
                        end
                        r_faults <= '0;
                        if (r_sel_trn) begin
                            r_mode <= 1'b1;
                        end
                        r_status <= ST_ADVANCE;
                        r_state  <= S_DONE;
                    end else begin
                        r_p     <= r_p + 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_DONE: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### sv/two_text_character_tracker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_text_character_tracker_core
// Follows incoming characters against a source and a translated text.
// ----------------------------------------------------------------------------
// Each request is worked on alone; the input is not ready until its result
// has moved into the output register. Store writes, restarts and null tests
// go from accept straight to handing off their result. A test runs the
// repeat check of each text tried (skipped at position zero), then a forward
// scan that reads one character at a time until a match, a stored null or
// the text length ends it. The pace is set by the single read port of
// each text RAM, whose registered read is followed by one shared compare.
// A result waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module two_text_character_tracker_core
    import tct_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request stream
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // entry_index[9:0], char_code[25:10]
    input  wire logic [IN_USER_W-1:0]  i_s_axis_tuser,  // cmd[1:0]
    // result stream
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,  // status[1:0], hit_count[17:2],
                                                        // fault_count[33:18],
                                                        // position[44:34],
                                                        // translated_mode[45]
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [LEN_W-1:0]      i_cfg_wdata
);

    t_ram_req          w_ram;
    logic [CHAR_W-1:0] w_src_rdata;
    logic [CHAR_W-1:0] w_trn_rdata;
    logic              w_out_free;
    logic              w_done;
    t_result           w_result;
    logic              r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // Output register takes a result when empty or being drained
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    tct_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .i_req_cmd   (t_cmd'(i_s_axis_tuser[CMD_W-1:0])),
        .i_req_index (i_s_axis_tdata[ADDR_W-1:0]),
        .i_req_char  (i_s_axis_tdata[ADDR_W +: CHAR_W]),
        .o_req_ready (o_s_axis_tready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_ram       (w_ram),
        .i_src_rdata (w_src_rdata),
        .i_trn_rdata (w_trn_rdata),
        .i_out_free  (w_out_free),
        .o_done      (w_done),
        .o_result    (w_result)
    );

    tct_text_ram #(
        .DEPTH (TEXT_DEPTH),
        .WIDTH (CHAR_W)
    ) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.src_we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_src_rdata)
    );

    tct_text_ram #(
        .DEPTH (TEXT_DEPTH),
        .WIDTH (CHAR_W)
    ) u_trn_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.trn_we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_trn_rdata)
    );

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_data <= OUT_DATA_W'(w_result);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

### sv/tct_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tct_checker
// Port-level checks on the tracker core, bound to the top level.
// ----------------------------------------------------------------------------
module tct_checker
    import tct_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_axis_tvalid,
    input wire logic                  o_s_axis_tready,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic [1:0]       w_status;
    logic [CNT_W-1:0] w_hits;
    logic [CNT_W-1:0] w_faults;

    assign w_status = o_m_axis_tdata[1:0];
    assign w_hits   = o_m_axis_tdata[2 +: CNT_W];
    assign w_faults = o_m_axis_tdata[2 + CNT_W +: CNT_W];

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // One request at a time: not ready right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request taken while another is in work");

    // Hit and fault runs never coexist
    a_runs_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_hits == '0) || (w_faults == '0))
        else $error("hit and fault counts both nonzero");

    // Advance clears faults and leaves a hit
    a_advance_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (w_status == ST_ADVANCE) |-> (w_faults == '0) && (w_hits != '0))
        else $error("advance with wrong counts");

    // Miss clears hits and leaves a fault
    a_miss_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (w_status == ST_MISS) |-> (w_hits == '0) && (w_faults != '0))
        else $error("miss with wrong counts");

endmodule

bind two_text_character_tracker_core tct_checker u_tct_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for two_text_character_tracker_core. A directed table
// loads short source and translated texts and walks repeats, forward matches,
// misses, null tests and restarts; random phases then follow the loaded texts
// with noise mixed in, under several sender and receiver idling patterns, and
// a closing burst of misses against empty texts runs the fault count up.
// Every result is compared field by field against an in-bench tracker
// prediction, or against the fixed result that a table row carries.
// ----------------------------------------------------------------------------
module tb;
    import tct_pkg::*;

    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int MISS_ITEMS     = 40;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int TAIL_CYCLES    = 20;

    typedef enum {ROW_REQ, ROW_LEN} t_row_kind;

    // ROW_LEN rows carry the source length in idx and the translated length in ch
    typedef struct {
        t_row_kind        kind;
        t_cmd             c;
        logic [9:0]       idx;
        logic [15:0]      ch;
        bit               typed;
        t_result          res;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;   // entry_index[9:0], char_code[25:10]
    logic [IN_USER_W-1:0]  i_s_axis_tuser = '0;   // cmd[1:0]
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;        // status[1:0], hit_count[17:2],
                                                  // fault_count[33:18], position[44:34],
                                                  // translated_mode[45]
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [LEN_W-1:0]      i_cfg_wdata = '0;

    // Shadow of the tracker: text stores, written flags, lengths and tracking state
    bit [CHAR_W-1:0] src_text [TEXT_DEPTH];
    bit [CHAR_W-1:0] trn_text [TEXT_DEPTH];
    bit              src_written [TEXT_DEPTH];
    bit              trn_written [TEXT_DEPTH];
    bit [LEN_W-1:0]  src_len;
    bit [LEN_W-1:0]  trn_len;
    bit [POS_W-1:0]  next_pos;
    bit [CNT_W-1:0]  hit_cnt;
    bit [CNT_W-1:0]  fault_cnt;
    bit              trn_mode;

    t_result  expected_results [$];
    t_dir_row dir_tab [$];

    int send_idle_pct;
    int recv_stall_pct;
    int err_cnt;
    int sent_cnt;
    int quiet_cycles;
    int n_adv, n_rep, n_miss, n_ack;

    two_text_character_tracker_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // Read one text entry; positions at or past the length read as null.
    // Note the first entry read that was never written (translated offset by depth).
    function automatic bit [CHAR_W-1:0] text_at(bit trn, int p, inout int gap);
        int lim;
        lim = trn ? int'(trn_len) : int'(src_len);
        if (p >= lim) return '0;
        if (gap < 0 && !(trn ? trn_written[p] : src_written[p]))
            gap = trn ? TEXT_DEPTH + p : p;
        return trn ? trn_text[p] : src_text[p];
    endfunction

    // Repeat check, then forward scan up to the first null
    function automatic t_status scan_text(bit trn, bit [CHAR_W-1:0] ch,
                                          inout bit [POS_W-1:0] pos,
                                          inout bit [CNT_W-1:0] h,
                                          inout bit [CNT_W-1:0] f, inout int gap);
        bit [CHAR_W-1:0] c;
        if (pos > 0 && text_at(trn, int'(pos) - 1, gap) == ch) return ST_REPEAT;
        for (int p = int'(pos); p < TEXT_DEPTH; p++) begin
            c = text_at(trn, p, gap);
            if (c == '0) break;
            if (c == ch) begin
                pos = POS_W'(p + 1);
                if (h != COUNT_MAX) h++;
                f = '0;
                return ST_ADVANCE;
            end
        end
        return ST_MISS;
    endfunction

    // Work out the result of one request; commit updates the shadow state
    function automatic t_result track_request(t_cmd c, bit [9:0] idx, bit [CHAR_W-1:0] ch,
                                              bit commit, output int gap);
        t_result         r;
        bit [POS_W-1:0]  pos;
        bit [CNT_W-1:0]  h;
        bit [CNT_W-1:0]  f;
        bit              m;
        t_status         st;
        pos = next_pos;
        h   = hit_cnt;
        f   = fault_cnt;
        m   = trn_mode;
        st  = ST_ACK;
        gap = -1;
        case (c)
            CMD_WR_SRC: begin
                if (commit) begin
                    src_text[idx]    = ch;
                    src_written[idx] = 1'b1;
                end
            end
            CMD_WR_TRN: begin
                if (commit) begin
                    trn_text[idx]    = ch;
                    trn_written[idx] = 1'b1;
                end
            end
            CMD_RESTART: begin
                pos = '0;
                h   = '0;
                f   = '0;
                m   = 1'b0;
            end
            default: begin
                if (ch != '0) begin
                    st = ST_MISS;
                    if (!m) st = scan_text(1'b0, ch, pos, h, f, gap);
                    if (st == ST_MISS) begin
                        st = scan_text(1'b1, ch, pos, h, f, gap);
                        if (st == ST_ADVANCE) m = 1'b1;
                    end
                    if (st == ST_MISS) begin
                        h = '0;
                        if (f != COUNT_MAX) f++;
                    end
                end
            end
        endcase
        if (commit) begin
            next_pos  = pos;
            hit_cnt   = h;
            fault_cnt = f;
            trn_mode  = m;
        end
        r.status = st;
        r.hits   = h;
        r.faults = f;
        r.pos    = pos;
        r.mode   = m;
        return r;
    endfunction

    function automatic t_result res(t_status st, int h, int f, int p, int m);
        t_result r;
        r.status = st;
        r.hits   = CNT_W'(h);
        r.faults = CNT_W'(f);
        r.pos    = POS_W'(p);
        r.mode   = m[0];
        return r;
    endfunction

    // Mostly a small alphabet so texts repeat and match; sometimes any nonzero code
    function automatic bit [CHAR_W-1:0] pick_char();
        if ($urandom_range(4) != 0) return CHAR_W'(16'h0041 + $urandom_range(7));
        return CHAR_W'($urandom_range(1, 65535));
    endfunction

    function automatic int pick_len(int n);
        int r;
        r = $urandom_range(9);
        if (r < 5) return n;
        if (r < 8) return $urandom_range(1023, n);
        return $urandom_range(n);
    endfunction

    task automatic add_row(t_row_kind k, t_cmd c, int idx, int ch,
                           bit typed = 1'b0, t_result r = '0);
        t_dir_row row;
        row.kind  = k;
        row.c     = c;
        row.idx   = ADDR_W'(idx);
        row.ch    = CHAR_W'(ch);
        row.typed = typed;
        row.res   = r;
        dir_tab.push_back(row);
    endtask

    // Predict, queue the expectation, then offer the request until it is taken
    task automatic send_req(t_cmd c, logic [9:0] idx, logic [CHAR_W-1:0] ch,
                            bit use_typed = 1'b0, t_result typed = '0);
        t_result e;
        int      gap;
        e = track_request(c, idx, ch, 1'b1, gap);
        if (use_typed) e = typed;
        expected_results.push_back(e);
        case (e.status)
            ST_ADVANCE: n_adv++;
            ST_REPEAT:  n_rep++;
            ST_MISS:    n_miss++;
            default:    n_ack++;
        endcase
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'b0, ch, idx};
        i_s_axis_tuser  <= {6'b0, c};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sent_cnt++;
    endtask

    // Fill any never-written entry the test would read before sending it
    task automatic send_test(logic [CHAR_W-1:0] ch);
        int gap;
        while (1) begin
            void'(track_request(CMD_TEST, '0, ch, 1'b0, gap));
            if (gap < 0) break;
            send_req(t_cmd'(gap >= TEXT_DEPTH ? CMD_WR_TRN : CMD_WR_SRC),
                     ADDR_W'(gap % TEXT_DEPTH),
                     $urandom_range(3) == 0 ? 16'h0000 : pick_char());
        end
        send_req(CMD_TEST, ADDR_W'($urandom_range(1023)), ch);
    endtask

    // Hold the sender until every expected result has come back
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_lengths(int s, int t);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_SRC_LEN;
        i_cfg_wdata <= LEN_W'(s);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_TRN_LEN;
        i_cfg_wdata <= LEN_W'(t);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        src_len = LEN_W'(s);
        trn_len = LEN_W'(t);
    endtask

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // Randomly stall the result side
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                err_cnt++;
                $display("%0t: result with none expected, actual %h", $time, o_m_axis_tdata);
            end else begin
                want = expected_results.pop_front();
                check_field("status", 32'(want.status), 32'(o_m_axis_tdata[1:0]));
                check_field("hit_count", 32'(want.hits), 32'(o_m_axis_tdata[17:2]));
                check_field("fault_count", 32'(want.faults), 32'(o_m_axis_tdata[33:18]));
                check_field("position", 32'(want.pos), 32'(o_m_axis_tdata[44:34]));
                check_field("translated_mode", 32'(want.mode), 32'(o_m_axis_tdata[45]));
            end
        end
    end

    // Count cycles in which neither side moves a request or a result
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no progress in %0d cycles", $time, WATCHDOG_LIMIT);
        $display("two_text_character_tracker_core test failed");
        $finish;
    end

    initial begin : stimulus
        int          n_src;
        int          n_trn;
        int          phase;
        int          pick;
        int          ahead;
        int          rand_start;
        logic [15:0] ch;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty texts: a test misses, a null test is ignored, far-end writes ack
        add_row(ROW_REQ, CMD_TEST,    0,    'h0041, 1'b1, res(ST_MISS, 0, 1, 0, 0));
        add_row(ROW_REQ, CMD_TEST,    0,    'h0000, 1'b1, res(ST_ACK, 0, 1, 0, 0));
        add_row(ROW_REQ, CMD_WR_SRC,  1023, 'hFFFF, 1'b1, res(ST_ACK, 0, 1, 0, 0));
        add_row(ROW_REQ, CMD_WR_TRN,  1023, 'h0001, 1'b1, res(ST_ACK, 0, 1, 0, 0));
        add_row(ROW_REQ, CMD_RESTART, 1023, 'hFFFF, 1'b1, res(ST_ACK, 0, 0, 0, 0));
        // Source "A B FFFF null", translated "X Y FFFF null"
        add_row(ROW_REQ, CMD_WR_SRC,  0,    'h0041, 1'b1, res(ST_ACK, 0, 0, 0, 0));
        add_row(ROW_REQ, CMD_WR_SRC,  1,    'h0042, 1'b1, res(ST_ACK, 0, 0, 0, 0));
        add_row(ROW_REQ, CMD_WR_SRC,  2,    'hFFFF, 1'b1, res(ST_ACK, 0, 0, 0, 0));
        add_row(ROW_REQ, CMD_WR_SRC,  3,    'h0000, 1'b1, res(ST_ACK, 0, 0, 0, 0));
        add_row(ROW_REQ, CMD_WR_TRN,  0,    'h0058, 1'b1, res(ST_ACK, 0, 0, 0, 0));
        add_row(ROW_REQ, CMD_WR_TRN,  1,    'h0059, 1'b1, res(ST_ACK, 0, 0, 0, 0));
        add_row(ROW_REQ, CMD_WR_TRN,  2,    'hFFFF, 1'b1, res(ST_ACK, 0, 0, 0, 0));
        add_row(ROW_REQ, CMD_WR_TRN,  3,    'h0000, 1'b1, res(ST_ACK, 0, 0, 0, 0));
        // Full-length source ends at its stored null; translated ends at length 3
        add_row(ROW_LEN, CMD_TEST,    1023, 3);
        add_row(ROW_REQ, CMD_TEST,    0,    'h0041);
        add_row(ROW_REQ, CMD_TEST,    0,    'h0041);
        add_row(ROW_REQ, CMD_TEST,    0,    'hFFFF);
        add_row(ROW_REQ, CMD_TEST,    0,    'h0042);
        add_row(ROW_REQ, CMD_TEST,    0,    'h0001);
        add_row(ROW_REQ, CMD_RESTART, 0,    'h0000, 1'b1, res(ST_ACK, 0, 0, 0, 0));
        // Translated match sets translated mode; source is skipped afterwards
        add_row(ROW_REQ, CMD_TEST,    0,    'h0058);
        add_row(ROW_REQ, CMD_TEST,    0,    'h0041);
        add_row(ROW_REQ, CMD_TEST,    0,    'h0058);
        add_row(ROW_REQ, CMD_TEST,    0,    'h0059);
        add_row(ROW_LEN, CMD_TEST,    0,    1023);
        add_row(ROW_REQ, CMD_TEST,    0,    'hFFFF);
        add_row(ROW_REQ, CMD_RESTART, 0,    'h0000, 1'b1, res(ST_ACK, 0, 0, 0, 0));

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_LEN) begin
                drain();
                set_lengths(int'(dir_tab[i].idx), int'(dir_tab[i].ch));
            end else begin
                send_req(dir_tab[i].c, dir_tab[i].idx, dir_tab[i].ch,
                         dir_tab[i].typed, dir_tab[i].res);
            end
        end

        // Random phases: load fresh texts, then follow them with noise mixed in
        rand_start = sent_cnt;
        phase = 0;
        while (sent_cnt - rand_start < RANDOM_ITEMS) begin
            drain();
            case (phase % 5)
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                3: begin send_idle_pct = 21; recv_stall_pct = 21; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            n_src = ($urandom_range(7) == 0) ? $urandom_range(300) : $urandom_range(24);
            n_trn = ($urandom_range(7) == 0) ? $urandom_range(300) : $urandom_range(24);
            set_lengths(pick_len(n_src), pick_len(n_trn));
            send_req(CMD_RESTART, ADDR_W'($urandom_range(1023)),
                     CHAR_W'($urandom_range(65535)));
            for (int i = 0; i < n_src; i++) send_req(CMD_WR_SRC, ADDR_W'(i), pick_char());
            if (src_len > n_src) send_req(CMD_WR_SRC, ADDR_W'(n_src), 16'h0000);
            for (int i = 0; i < n_trn; i++) send_req(CMD_WR_TRN, ADDR_W'(i), pick_char());
            if (trn_len > n_trn) send_req(CMD_WR_TRN, ADDR_W'(n_trn), 16'h0000);

            repeat ($urandom_range(80, 20)) begin
                pick = $urandom_range(99);
                if (pick < 4) begin
                    send_req(CMD_RESTART, ADDR_W'($urandom_range(1023)),
                             CHAR_W'($urandom_range(65535)));
                end else if (pick < 10) begin
                    send_req(t_cmd'($urandom_range(1) ? CMD_WR_SRC : CMD_WR_TRN),
                             ADDR_W'($urandom_range(1023)),
                             $urandom_range(3) == 0 ? pick_char()
                                                    : CHAR_W'($urandom_range(65535)));
                end else begin
                    if (pick < 60) begin
                        // next characters of the text being followed
                        ahead = int'(next_pos) + $urandom_range(2);
                        if (ahead > TEXT_DEPTH - 1) ahead = TEXT_DEPTH - 1;
                        ch = trn_mode ? trn_text[ahead] : src_text[ahead];
                    end else if (pick < 70) begin
                        // character just behind the position
                        if (next_pos > 0)
                            ch = trn_mode ? trn_text[next_pos - 1] : src_text[next_pos - 1];
                        else
                            ch = pick_char();
                    end else if (pick < 78) begin
                        ch = $urandom_range(1) ? trn_text[$urandom_range(31)]
                                               : src_text[$urandom_range(31)];
                    end else if (pick < 95) begin
                        ch = 16'($urandom_range(65535));
                    end else begin
                        ch = 16'h0000;
                    end
                    send_test(ch);
                end
            end
            phase++;
        end

        // Empty texts and a run of misses push the fault count up
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_lengths(0, 0);
        send_req(CMD_RESTART, ADDR_W'($urandom_range(1023)), CHAR_W'($urandom_range(65535)));
        repeat (MISS_ITEMS)
            send_req(CMD_TEST, ADDR_W'($urandom_range(1023)),
                     CHAR_W'($urandom_range(65535, 1)));

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests over %0d random phases and a closing run of misses",
                 sent_cnt, phase);
        $display("Outcomes: %0d advances, %0d repeats, %0d misses, %0d acks",
                 n_adv, n_rep, n_miss, n_ack);
        if (err_cnt == 0 && expected_results.size() == 0) begin
            $display("two_text_character_tracker_core test passed");
        end else begin
            $display("%0d mismatches, %0d results still expected", err_cnt,
                     expected_results.size());
            $display("two_text_character_tracker_core test failed");
        end
        $finish;
    end

endmodule
